// ===== hw/rtl/htmr_pkg.sv =====
// Package for the handheld console timer: shared constants, register codes,
// the result record type and the period shift function. No dependencies.
package htmr_pkg;

    localparam int DIV_W   = 8;
    localparam int CNT_W   = 8;
    localparam int CTRL_W  = 3;
    localparam int PRE_W   = 11;
    localparam int CYC_W   = 8;
    localparam int CTI_W   = 19;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SEL_DIV  = 2'd0;
    localparam logic [1:0] SEL_TIMA = 2'd1;
    localparam logic [1:0] SEL_TMA  = 2'd2;
    localparam logic [1:0] SEL_TAC  = 2'd3;

    localparam int CTRL_EN_BIT = 2;

    localparam logic [PRE_W-1:0] PRESCALE_MAX   = '1;
    localparam logic [CTI_W-1:0] DISABLED_COUNT = CTI_W'(1 << 16);

    typedef struct packed {
        logic             timer_interrupt;
        logic [DIV_W-1:0] div_value;
        logic [CNT_W-1:0] tima_value;
        logic [CTI_W-1:0] cycles_to_interrupt;
    } result_t;

    // log2 of the prescale period: 1024, 16, 64, 256
    function automatic logic [3:0] period_shift(input logic [1:0] rate_sel);
        logic [3:0] sh;
        unique case (rate_sel)
            2'd0:    sh = 4'd10;
            2'd1:    sh = 4'd4;
            2'd2:    sh = 4'd6;
            default: sh = 4'd8;
        endcase
        return sh;
    endfunction

endpackage

// ===== hw/rtl/htmr_core.sv =====
// Timer state and single-pass step logic for the handheld console timer.
// Depends on htmr_pkg; produces the next result record for each transaction.
module htmr_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic                          op,
    input  logic [htmr_pkg::CYC_W-1:0]    cycles,
    input  logic [1:0]                    reg_select,
    input  logic [htmr_pkg::CNT_W-1:0]    write_value,
    output htmr_pkg::result_t             result
);
    import htmr_pkg::*;

    logic [DIV_W-1:0]  div_reg,  div_next;
    logic [7:0]        sub_reg,  sub_next;
    logic [CNT_W-1:0]  tc_reg,   tc_next;
    logic [CNT_W-1:0]  tm_reg,   tm_next;
    logic [CTRL_W-1:0] ctrl_reg, ctrl_next;
    logic [PRE_W-1:0]  pre_reg,  pre_next;
    logic              irq;

    always_comb begin
        logic [8:0]       sub_sum;
        logic [PRE_W:0]   pre_sum;
        logic [PRE_W:0]   pre_adj;
        logic [PRE_W:0]   period;
        logic [CTI_W-1:0] total;
        logic [CTI_W-1:0] pre_ext;

        div_next  = div_reg;
        sub_next  = sub_reg;
        tc_next   = tc_reg;
        tm_next   = tm_reg;
        ctrl_next = ctrl_reg;
        pre_next  = pre_reg;
        irq       = 1'b0;

        sub_sum = {1'b0, sub_reg} + {1'b0, cycles};
        pre_sum = {1'b0, pre_reg} + (PRE_W+1)'(cycles);
        period  = (PRE_W+1)'(1) << period_shift(ctrl_reg[1:0]);
        pre_adj = pre_sum;

        if (op == OP_TICK) begin
            div_next = div_reg + DIV_W'(sub_sum[8]);
            sub_next = sub_sum[7:0];
            if (ctrl_reg[CTRL_EN_BIT]) begin
                if (pre_sum >= period) begin
                    pre_adj = pre_sum - period;
                    if (tc_reg == '1) begin
                        tc_next = tm_reg;
                        irq     = 1'b1;
                    end else begin
                        tc_next = tc_reg + CNT_W'(1);
                    end
                end
                pre_next = pre_adj[PRE_W] ? PRESCALE_MAX : pre_adj[PRE_W-1:0];
            end
        end else begin
            unique case (reg_select)
                SEL_DIV: begin
                    div_next = '0;
                    sub_next = '0;
                    pre_next = '0;
                end
                SEL_TIMA: tc_next   = write_value;
                SEL_TMA:  tm_next   = write_value;
                SEL_TAC:  ctrl_next = write_value[CTRL_W-1:0];
                default:  ctrl_next = ctrl_reg;
            endcase
        end

        total   = CTI_W'(9'd256 - {1'b0, tc_next}) << period_shift(ctrl_next[1:0]);
        pre_ext = CTI_W'(pre_next);

        result.timer_interrupt = irq;
        result.div_value       = div_next;
        result.tima_value      = tc_next;
        if (!ctrl_next[CTRL_EN_BIT]) begin
            result.cycles_to_interrupt = DISABLED_COUNT;
        end else if (pre_ext >= total) begin
            result.cycles_to_interrupt = '0;
        end else begin
            result.cycles_to_interrupt = total - pre_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg  <= '0;
            sub_reg  <= '0;
            tc_reg   <= '0;
            tm_reg   <= '0;
            ctrl_reg <= '0;
            pre_reg  <= '0;
        end else if (step_en) begin
            div_reg  <= div_next;
            sub_reg  <= sub_next;
            tc_reg   <= tc_next;
            tm_reg   <= tm_next;
            ctrl_reg <= ctrl_next;
            pre_reg  <= pre_next;
        end
    end

endmodule

// ===== hw/rtl/handheld_console_timer.sv =====
// Top level of the handheld console timer: input register, step core, result register.
// Depends on htmr_pkg and htmr_core.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    s_op, s_cycles, s_reg_select, s_write_value
//  m_       out  m_valid/m_ready    m_timer_interrupt, m_div_value, m_tima_value,
//                                   m_cycles_to_interrupt
//
// One transaction per cycle sustained while the result is not stalled; an accepted input
// passes through the input register, then the step logic into the result register.
// Reset (aresetn low, synchronous) clears all timer state and both valid flags.
// A stalled result holds the input register; s_ready drops only when both registers
// are full and m_ready is low.
module handheld_console_timer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [htmr_pkg::CYC_W-1:0]         s_cycles,
    input  logic [1:0]                         s_reg_select,
    input  logic [htmr_pkg::CNT_W-1:0]         s_write_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_timer_interrupt,
    output logic [htmr_pkg::DIV_W-1:0]         m_div_value,
    output logic [htmr_pkg::CNT_W-1:0]         m_tima_value,
    output logic [htmr_pkg::CTI_W-1:0]         m_cycles_to_interrupt
);
    import htmr_pkg::*;

    logic             in_valid_reg;
    logic             op_reg;
    logic [CYC_W-1:0] cycles_reg;
    logic [1:0]       sel_reg;
    logic [CNT_W-1:0] wval_reg;
    logic             out_valid_reg;
    result_t          res_reg;
    result_t          res_next;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    htmr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .op          (op_reg),
        .cycles      (cycles_reg),
        .reg_select  (sel_reg),
        .write_value (wval_reg),
        .result      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= s_op;
            cycles_reg <= s_cycles;
            sel_reg    <= s_reg_select;
            wval_reg   <= s_write_value;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_timer_interrupt     = res_reg.timer_interrupt;
    assign m_div_value           = res_reg.div_value;
    assign m_tima_value          = res_reg.tima_value;
    assign m_cycles_to_interrupt = res_reg.cycles_to_interrupt;

endmodule
